/* hw/rtl/rrfts_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin / FCFS task scheduler package
// Shared widths, codes and record types of the scheduler blocks.
// ----------------------------------------------------------------------------
package rrfts_pkg;

  localparam int TIME_W      = 32;
  localparam int ID_W        = 4;
  localparam int NUM_IDS     = 1 << ID_W;
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 2;
  localparam int ADDR_W      = REG_IDX_W + 2;

  localparam int NUM_LANES  = 4;
  localparam int LANE_START = 0;
  localparam int LANE_RESP  = 1;
  localparam int LANE_EXEC  = 2;
  localparam int LANE_WAIT  = 3;

  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_RUNNING = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_KILLED  = 2'd1;

  localparam logic MODE_RR   = 1'b0;
  localparam logic MODE_FCFS = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_ALGORITHM_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TICK_TIME      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_TASK_ID   = 2'd2;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [ID_W-1:0]   task_id_t;
  typedef logic [NUM_LANES-1:0][TIME_W-1:0] task_row_t;

  localparam time_t    TICK_TIME_RESET = 32'd10;
  localparam task_id_t IDLE_ID_RESET   = 4'd0;
  localparam task_id_t NEXT_ID_RESET   = 4'd1;

  typedef struct packed {
    logic     algorithm_mode;
    time_t    tick_time;
    task_id_t idle_task_id;
  } cfg_t;

  typedef struct packed {
    logic     push;
    task_id_t push_id;
    logic     pop;
  } queue_op_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] en;
    task_id_t             addr;
    task_row_t            row;
  } row_write_t;

  typedef struct packed {
    task_id_t task_out;
    logic     ok;
    task_id_t prev_task;
    time_t    prev_exec_time;
    time_t    prev_waiting_time;
    time_t    next_response_time;
  } result_t;

endpackage

/* hw/rtl/rrfts_if.sv */
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for scheduler commands and their results.
// ----------------------------------------------------------------------------
interface rrfts_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [rrfts_pkg::KIND_W-1:0]   kind;
  rrfts_pkg::time_t              now;
  logic [rrfts_pkg::STATUS_W-1:0] outgoing_status;

  modport source (output valid, kind, now, outgoing_status, input ready);
  modport sink (input valid, kind, now, outgoing_status, output ready);
endinterface

interface rrfts_res_if;
  logic                 valid;
  logic                 ready;
  rrfts_pkg::task_id_t  task_out;
  logic                 ok;
  rrfts_pkg::task_id_t  prev_task;
  rrfts_pkg::time_t     prev_exec_time;
  rrfts_pkg::time_t     prev_waiting_time;
  rrfts_pkg::time_t     next_response_time;

  modport source (output valid, task_out, ok, prev_task, prev_exec_time, prev_waiting_time,
                  next_response_time, input ready);
  modport sink (input valid, task_out, ok, prev_task, prev_exec_time, prev_waiting_time,
                next_response_time, output ready);
endinterface

/* hw/rtl/round_robin_fcfs_task_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Round-robin / FCFS task scheduler
// Creates tasks, starts the first task and performs context switches.
//
//   Channel  Kind        Carries
//   cmd      valid/ready kind, now, outgoing_status
//   res      valid/ready task_out, ok, prev_task, prev_exec_time,
//                        prev_waiting_time, next_response_time
//   config   APB         algorithm_mode 0x0, tick_time 0x4, idle_task_id 0x8
//
// A create, a start or an ignored kind finishes in ST_FETCH; a scheduling event
// goes on to ST_NEXT, as it reads the ready queue and then the incoming task's row
// of the time table through its single read port. A command is taken while a
// finished result still sits in the output register; a blocked result is held
// until the sink takes it. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_fcfs_task_scheduler_top (
  input  logic                         clk,
  input  logic                         rst,
  rrfts_cmd_if.sink                    cmd,
  rrfts_res_if.source                  res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrfts_pkg::ADDR_W-1:0] paddr,
  input  logic [rrfts_pkg::DATA_W-1:0] pwdata,
  output logic [rrfts_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_NEXT  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  rrfts_pkg::cfg_t cfg;

  logic [rrfts_pkg::KIND_W-1:0]   item_kind;
  rrfts_pkg::time_t               item_now;
  logic [rrfts_pkg::STATUS_W-1:0] item_status;

  rrfts_pkg::task_id_t running_task;
  rrfts_pkg::task_id_t running_task_next;
  rrfts_pkg::task_id_t next_id;
  rrfts_pkg::task_id_t next_id_next;
  rrfts_pkg::task_id_t cur_id;
  rrfts_pkg::task_id_t nxt_id;
  rrfts_pkg::task_id_t nxt_sel;
  rrfts_pkg::time_t    cur_exec;
  rrfts_pkg::time_t    cur_wait;
  rrfts_pkg::time_t    exec_upd;
  rrfts_pkg::time_t    wait_upd;
  rrfts_pkg::time_t    nxt_wait;

  rrfts_pkg::queue_op_t         qop;
  rrfts_pkg::task_id_t          q_head_id;
  logic [rrfts_pkg::QCNT_W-1:0] q_count;
  logic                         q_full;
  logic                         q_empty;

  rrfts_pkg::row_write_t twr;
  rrfts_pkg::task_id_t   t_rd_addr;
  rrfts_pkg::task_row_t  t_rd_row;
  rrfts_pkg::task_row_t  fwd_row;

  rrfts_pkg::result_t res_d;
  rrfts_pkg::result_t hold;
  rrfts_pkg::result_t out_data;
  logic               out_valid;
  logic               out_free;
  logic               fin;
  logic               fcfs;
  logic               pushed;
  logic               killed;

  rrfts_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rrfts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .op      (qop),
    .head_id (q_head_id),
    .count   (q_count)
  );

  rrfts_task_mem u_task_mem (
    .clk     (clk),
    .rd_addr (t_rd_addr),
    .rd_row  (t_rd_row),
    .wr      (twr)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign out_free  = !out_valid || res.ready;

  always_comb begin
    fcfs    = (cfg.algorithm_mode == rrfts_pkg::MODE_FCFS);
    q_full  = (q_count == rrfts_pkg::QCNT_W'(rrfts_pkg::QUEUE_DEPTH));
    q_empty = (q_count == '0);
    pushed  = !fcfs && (item_status == rrfts_pkg::STATUS_RUNNING) && !q_full;
    killed  = !fcfs && (item_status == rrfts_pkg::STATUS_KILLED);

    if (!q_empty) begin
      nxt_sel = q_head_id;
    end else if (pushed) begin
      nxt_sel = running_task;
    end else begin
      nxt_sel = cfg.idle_task_id;
    end

    if (fcfs) begin
      exec_upd = t_rd_row[rrfts_pkg::LANE_EXEC]
               + (item_now - t_rd_row[rrfts_pkg::LANE_RESP]);
    end else begin
      exec_upd = t_rd_row[rrfts_pkg::LANE_EXEC] + cfg.tick_time;
    end
    if (killed) begin
      wait_upd = item_now - t_rd_row[rrfts_pkg::LANE_START] - t_rd_row[rrfts_pkg::LANE_EXEC];
    end else begin
      wait_upd = t_rd_row[rrfts_pkg::LANE_WAIT];
    end

    // The outgoing row was written in the same cycle the incoming row was read.
    fwd_row = t_rd_row;
    if (nxt_id == cur_id) begin
      fwd_row[rrfts_pkg::LANE_EXEC] = cur_exec;
      fwd_row[rrfts_pkg::LANE_WAIT] = cur_wait;
    end
    nxt_wait = fwd_row[rrfts_pkg::LANE_WAIT] + (item_now - fwd_row[rrfts_pkg::LANE_START]);

    qop               = '0;
    twr               = '0;
    res_d             = '0;
    res_d.task_out    = running_task;
    running_task_next = running_task;
    next_id_next      = next_id;
    t_rd_addr         = running_task;
    fin               = 1'b0;

    case (state)
      ST_FETCH: begin
        case (item_kind)
          rrfts_pkg::KIND_CREATE: begin
            fin                             = 1'b1;
            qop.push                        = !q_full;
            qop.push_id                     = next_id;
            twr.en                          = '1;
            twr.addr                        = next_id;
            twr.row[rrfts_pkg::LANE_START]  = item_now;
            next_id_next                    = next_id + rrfts_pkg::task_id_t'(1);
            res_d.task_out                  = next_id;
            res_d.ok                        = !q_full;
          end
          rrfts_pkg::KIND_START: begin
            fin = 1'b1;
            if (!q_empty) begin
              qop.pop                           = 1'b1;
              running_task_next                 = q_head_id;
              twr.en[rrfts_pkg::LANE_START]     = 1'b1;
              twr.en[rrfts_pkg::LANE_RESP]      = 1'b1;
              twr.addr                          = q_head_id;
              twr.row[rrfts_pkg::LANE_START]    = item_now;
              twr.row[rrfts_pkg::LANE_RESP]     = item_now;
              res_d.task_out                    = q_head_id;
              res_d.ok                          = 1'b1;
              res_d.next_response_time          = item_now;
            end
          end
          rrfts_pkg::KIND_EVENT: begin
            qop.push                       = pushed;
            qop.push_id                    = running_task;
            qop.pop                        = 1'b1;
            twr.en[rrfts_pkg::LANE_EXEC]   = 1'b1;
            twr.en[rrfts_pkg::LANE_WAIT]   = killed;
            twr.addr                       = running_task;
            twr.row[rrfts_pkg::LANE_EXEC]  = exec_upd;
            twr.row[rrfts_pkg::LANE_WAIT]  = wait_upd;
            running_task_next              = nxt_sel;
            t_rd_addr                      = nxt_sel;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_NEXT: begin
        fin                           = 1'b1;
        twr.addr                      = nxt_id;
        twr.row[rrfts_pkg::LANE_RESP] = item_now;
        res_d.task_out                = nxt_id;
        res_d.ok                      = 1'b1;
        res_d.prev_task               = cur_id;
        res_d.prev_exec_time          = cur_exec;
        if (fcfs) begin
          twr.en[rrfts_pkg::LANE_RESP]  = 1'b1;
          twr.en[rrfts_pkg::LANE_WAIT]  = 1'b1;
          twr.row[rrfts_pkg::LANE_WAIT] = nxt_wait;
          res_d.next_response_time      = item_now;
          res_d.prev_waiting_time       = (nxt_id == cur_id) ? nxt_wait : cur_wait;
        end else begin
          twr.en[rrfts_pkg::LANE_RESP] = (fwd_row[rrfts_pkg::LANE_RESP] == '0);
          res_d.prev_waiting_time      = cur_wait;
          if (fwd_row[rrfts_pkg::LANE_RESP] == '0) begin
            res_d.next_response_time = item_now;
          end else begin
            res_d.next_response_time = fwd_row[rrfts_pkg::LANE_RESP];
          end
        end
      end
      ST_HOLD: begin
        fin   = 1'b1;
        res_d = hold;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (item_kind == rrfts_pkg::KIND_EVENT) begin
          state_next = ST_NEXT;
        end else begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_NEXT: begin
        state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_task <= '0;
      next_id      <= rrfts_pkg::NEXT_ID_RESET;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      running_task <= running_task_next;
      next_id      <= next_id_next;
      if (fin && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      item_kind   <= cmd.kind;
      item_now    <= cmd.now;
      item_status <= cmd.outgoing_status;
    end
    if (state == ST_FETCH) begin
      cur_id   <= running_task;
      nxt_id   <= nxt_sel;
      cur_exec <= exec_upd;
      cur_wait <= wait_upd;
    end
    if (fin && !out_free && state != ST_HOLD) begin
      hold <= res_d;
    end
    if (fin && out_free) begin
      out_data <= res_d;
    end
  end

  assign res.valid              = out_valid;
  assign res.task_out           = out_data.task_out;
  assign res.ok                 = out_data.ok;
  assign res.prev_task          = out_data.prev_task;
  assign res.prev_exec_time     = out_data.prev_exec_time;
  assign res.prev_waiting_time  = out_data.prev_waiting_time;
  assign res.next_response_time = out_data.next_response_time;

endmodule

/* hw/rtl/rrfts_queue.sv */
// ----------------------------------------------------------------------------
// Ready queue
// Ring buffer of ready task ids in a synchronous memory with head and count.
// ----------------------------------------------------------------------------
module rrfts_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  rrfts_pkg::queue_op_t         op,
  output rrfts_pkg::task_id_t          head_id,
  output logic [rrfts_pkg::QCNT_W-1:0] count
);

  rrfts_pkg::task_id_t mem [rrfts_pkg::QUEUE_DEPTH];

  logic [rrfts_pkg::QIDX_W-1:0] head;
  logic [rrfts_pkg::QIDX_W-1:0] head_next;
  logic [rrfts_pkg::QIDX_W:0]   tail_sum;
  logic [rrfts_pkg::QIDX_W-1:0] wr_addr;
  logic [rrfts_pkg::QCNT_W-1:0] filled;
  logic [rrfts_pkg::QCNT_W-1:0] count_next;

  always_comb begin
    tail_sum = {1'b0, head} + (rrfts_pkg::QIDX_W + 1)'(count);
    if (tail_sum >= (rrfts_pkg::QIDX_W + 1)'(rrfts_pkg::QUEUE_DEPTH)) begin
      wr_addr = rrfts_pkg::QIDX_W'(tail_sum - (rrfts_pkg::QIDX_W + 1)'(rrfts_pkg::QUEUE_DEPTH));
    end else begin
      wr_addr = rrfts_pkg::QIDX_W'(tail_sum);
    end
    filled = count + rrfts_pkg::QCNT_W'(op.push);
    if (op.pop && filled != '0) begin
      count_next = filled - rrfts_pkg::QCNT_W'(1);
    end else begin
      count_next = filled;
    end
    if (!op.pop) begin
      head_next = head;
    end else if (head == rrfts_pkg::QIDX_W'(rrfts_pkg::QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + rrfts_pkg::QIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wr_addr] <= op.push_id;
    end
    head_id <= mem[head];
  end

endmodule

/* hw/rtl/rrfts_task_mem.sv */
// ----------------------------------------------------------------------------
// Task time table
// Per-task start, response, execution and waiting times with lane writes.
// ----------------------------------------------------------------------------
module rrfts_task_mem (
  input  logic                   clk,
  input  rrfts_pkg::task_id_t    rd_addr,
  output rrfts_pkg::task_row_t   rd_row,
  input  rrfts_pkg::row_write_t  wr
);

  rrfts_pkg::task_row_t mem [rrfts_pkg::NUM_IDS];

  always_ff @(posedge clk) begin
    for (int l = 0; l < rrfts_pkg::NUM_LANES; l++) begin
      if (wr.en[l]) begin
        mem[wr.addr][l] <= wr.row[l];
      end
    end
    rd_row <= mem[rd_addr];
  end

endmodule

/* hw/rtl/rrfts_regs.sv */
// ----------------------------------------------------------------------------
// Scheduler configuration registers
// APB-style register file for scheduling mode, tick time and idle task.
// ----------------------------------------------------------------------------
module rrfts_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrfts_pkg::ADDR_W-1:0] paddr,
  input  logic [rrfts_pkg::DATA_W-1:0] pwdata,
  output logic [rrfts_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output rrfts_pkg::cfg_t              cfg
);

  logic [rrfts_pkg::REG_IDX_W-1:0] idx;
  logic                            wr_en;

  assign idx    = paddr[rrfts_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.algorithm_mode <= rrfts_pkg::MODE_RR;
      cfg.tick_time      <= rrfts_pkg::TICK_TIME_RESET;
      cfg.idle_task_id   <= rrfts_pkg::IDLE_ID_RESET;
    end else if (wr_en) begin
      case (idx)
        rrfts_pkg::REG_ALGORITHM_MODE: cfg.algorithm_mode <= pwdata[0];
        rrfts_pkg::REG_TICK_TIME:      cfg.tick_time <= pwdata;
        rrfts_pkg::REG_IDLE_TASK_ID:   cfg.idle_task_id <= pwdata[rrfts_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rrfts_pkg::REG_ALGORITHM_MODE: prdata = rrfts_pkg::DATA_W'(cfg.algorithm_mode);
      rrfts_pkg::REG_TICK_TIME:      prdata = cfg.tick_time;
      rrfts_pkg::REG_IDLE_TASK_ID:   prdata = rrfts_pkg::DATA_W'(cfg.idle_task_id);
      default:                       prdata = '0;
    endcase
  end

endmodule
